FILE: hdl/gbci_pkg.sv
// Shared types and constants for the gyro bias calibration and rate integration block.
// Register indexes, reset values, configuration struct and controller/datapath handshake structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbci_pkg;

   // Fixed register widths
   localparam int GAIN_W     = 24;
   localparam int STEP_W     = 24;
   localparam int CNT_W      = 13;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   // Axis lanes
   localparam int NUM_AXES = 3;
   localparam int AXIS_W   = 2;
   localparam logic [AXIS_W-1:0] AXIS_FIRST = 2'd0;
   localparam logic [AXIS_W-1:0] AXIS_LAST  = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIME_STEP   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SAMPLES = 2'd2;

   // Register reset values and count limits
   localparam logic [GAIN_W-1:0] RATE_GAIN_RESET   = 24'd146801;
   localparam logic [STEP_W-1:0] TIME_STEP_RESET   = 24'd83886;
   localparam logic [CNT_W-1:0]  CAL_SAMPLES_RESET = 13'd2000;
   localparam logic [CNT_W-1:0]  CAL_MIN           = 13'd1;
   localparam logic [CNT_W-1:0]  CAL_LIMIT         = 13'd4096;

   typedef struct packed {
      logic [GAIN_W-1:0] rate_gain;
      logic [STEP_W-1:0] time_step;
      logic [CNT_W-1:0]  cal_count;   // already clamped to 1..4096
   } cfg_type;

   typedef struct packed {
      logic load_sample;   // capture the accepted request
      logic cal_add;       // add sample into bias sums
      logic div_start;     // start the bias divider
      logic mul1;          // rate * gain stage
      logic mul2;          // scaled rate * time step stage
      logic acc_load;      // update angles and load result register
      logic cal_load;      // load a calibration result (zero angles)
   } dp_cmd_type;

   typedef struct packed {
      logic cal_reached;   // the sample being added completes the count
      logic div_busy;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: hdl/gbci_if.sv
// Channel interfaces: request samples, response angles, configuration writes.
// Depends on gbci_pkg for configuration widths.
`timescale 1ns / 1ps
`default_nettype none

interface gbci_req_if #(
   parameter int SAMPLE_BITS = 16
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] rate_x;
   logic signed [SAMPLE_BITS-1:0] rate_y;
   logic signed [SAMPLE_BITS-1:0] rate_z;

   modport source (output valid, output rate_x, output rate_y, output rate_z, input ready);
   modport sink   (input valid, input rate_x, input rate_y, input rate_z, output ready);
endinterface

interface gbci_rsp_if #(
   parameter int ANGLE_BITS = 48
);
   logic                         valid;
   logic                         ready;
   logic signed [ANGLE_BITS-1:0] angle_x;
   logic signed [ANGLE_BITS-1:0] angle_y;
   logic signed [ANGLE_BITS-1:0] angle_z;
   logic                         calibrating;

   modport source (output valid, output angle_x, output angle_y, output angle_z,
                   output calibrating, input ready);
   modport sink   (input valid, input angle_x, input angle_y, input angle_z,
                   input calibrating, output ready);
endinterface

interface gbci_csr_if import gbci_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/gyro_bias_calibrate_integrate.sv
// Channel      Dir  Contents
// req_ch       in   rate_x, rate_y, rate_z  (signed SAMPLE_BITS gyro rates)
// rsp_ch       out  angle_x/y/z (signed whole-unit Q48.0 ANGLE_BITS), calibrating
// csr_ch       in   index, data             (rate_gain, time_step, cal_samples)
//
// Tracking requests step through accept, gain multiply, time-step multiply and accumulate.
// Calibration requests step through accept, sum add and output; the request that completes the count
// also runs the shared restoring divider, one quotient bit per cycle, on each axis in turn.
// Reset (synchronous) clears sums, bias, angles and loads register defaults; no clearing pass.
// A result waits in the output register; the block computes the next request meanwhile and
// holds it only if the previous result has not been taken.
// Depends on gbci_pkg, gbci_if, gbci_csr, gbci_ctrl and gbci_dp.
`timescale 1ns / 1ps
`default_nettype none

module gyro_bias_calibrate_integrate import gbci_pkg::*; #(
   parameter int SAMPLE_BITS   = 16,
   parameter int ANGLE_BITS    = 48,
   parameter int FRACTION_BITS = 24
) (
   input wire logic    clock,
   input wire logic    reset,
   gbci_req_if.sink    req_ch,
   gbci_rsp_if.source  rsp_ch,
   gbci_csr_if.sink    csr_ch
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   // configuration registers
   gbci_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   // sequencing
   gbci_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   gbci_dp #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .ANGLE_BITS    (ANGLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .cfg             (cfg),
      .in_rate_x       (req_ch.rate_x),
      .in_rate_y       (req_ch.rate_y),
      .in_rate_z       (req_ch.rate_z),
      .out_angle_x     (rsp_ch.angle_x),
      .out_angle_y     (rsp_ch.angle_y),
      .out_angle_z     (rsp_ch.angle_z),
      .out_calibrating (rsp_ch.calibrating)
   );

endmodule

`default_nettype wire

FILE: hdl/gbci_csr.sv
// Configuration registers: rate gain, time step, calibration count (clamped on write).
// Depends on gbci_pkg and gbci_csr_if.
`timescale 1ns / 1ps
`default_nettype none

module gbci_csr import gbci_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   gbci_csr_if.sink   csr_ch,
   output cfg_type    cfg
);

   cfg_type          cfg_ff;
   logic [CNT_W-1:0] count_raw;
   logic [CNT_W-1:0] count_in;

   // writes never stall
   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   // only the low CNT_W data bits count: zero acts as one, anything above the limit acts as the limit
   always_comb begin
      count_raw = csr_ch.data[CNT_W-1:0];
      if (count_raw == '0) begin
         count_in = CAL_MIN;
      end else if (count_raw > CAL_LIMIT) begin
         count_in = CAL_LIMIT;
      end else begin
         count_in = count_raw;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate_gain <= RATE_GAIN_RESET;
         cfg_ff.time_step <= TIME_STEP_RESET;
         cfg_ff.cal_count <= CAL_SAMPLES_RESET;
      end else if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_RATE_GAIN:   cfg_ff.rate_gain <= csr_ch.data[GAIN_W-1:0];
            CSR_TIME_STEP:   cfg_ff.time_step <= csr_ch.data[STEP_W-1:0];
            CSR_CAL_SAMPLES: cfg_ff.cal_count <= count_in;
            default: ;  // unmapped index, ignored
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gbci_ctrl.sv
// Controller FSM: sequences calibration sums, bias division, the two multiply stages and the accumulate.
// Depends on gbci_pkg for the command and status structs.
`timescale 1ns / 1ps
`default_nettype none

module gbci_ctrl import gbci_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CAL_ADD,
      ST_DIV_START,
      ST_DIV,
      ST_CAL_OUT,
      ST_MUL1,
      ST_MUL2,
      ST_ACC
   } state_type;

   state_type state_ff;
   logic      cal_done_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // command decode
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE:      cmd.load_sample = req_valid;
         ST_CAL_ADD:   cmd.cal_add     = 1'b1;
         ST_DIV_START: cmd.div_start   = 1'b1;
         ST_CAL_OUT:   cmd.cal_load    = out_free;
         ST_MUL1:      cmd.mul1        = 1'b1;
         ST_MUL2:      cmd.mul2        = 1'b1;
         ST_ACC:       cmd.acc_load    = out_free;
         default: ;
      endcase
   end

   // state, calibration flag, response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cal_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.cal_load || cmd.acc_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= cal_done_ff ? ST_MUL1 : ST_CAL_ADD;
               end
            end
            ST_CAL_ADD: begin
               if (status.cal_reached) begin
                  cal_done_ff <= 1'b1;
                  state_ff    <= ST_DIV_START;
               end else begin
                  state_ff <= ST_CAL_OUT;
               end
            end
            ST_DIV_START: state_ff <= ST_DIV;
            ST_DIV: begin
               if (!status.div_busy) begin
                  state_ff <= ST_CAL_OUT;
               end
            end
            ST_CAL_OUT: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_MUL1: state_ff <= ST_MUL2;
            ST_MUL2: state_ff <= ST_ACC;
            ST_ACC: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hdl/gbci_dp.sv
// Datapath: per-axis bias sums, shared restoring divider, two multiply stages, angle accumulators.
// Depends on gbci_pkg for command/status/config structs and widths.
`timescale 1ns / 1ps
`default_nettype none

module gbci_dp import gbci_pkg::*; #(
   parameter int SAMPLE_BITS   = 16,
   parameter int ANGLE_BITS    = 48,
   parameter int FRACTION_BITS = 24
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire dp_cmd_type                    cmd,
   output dp_status_type                      status,
   input  wire cfg_type                       cfg,
   input  wire logic signed [SAMPLE_BITS-1:0] in_rate_x,
   input  wire logic signed [SAMPLE_BITS-1:0] in_rate_y,
   input  wire logic signed [SAMPLE_BITS-1:0] in_rate_z,
   output logic signed [ANGLE_BITS-1:0]       out_angle_x,
   output logic signed [ANGLE_BITS-1:0]       out_angle_y,
   output logic signed [ANGLE_BITS-1:0]       out_angle_z,
   output logic                               out_calibrating
);

   localparam int SUM_W   = SAMPLE_BITS + CNT_W - 1;
   localparam int D_W     = SAMPLE_BITS + 1;
   localparam int P1_W    = D_W + GAIN_W + 1;
   localparam int R_W     = P1_W - FRACTION_BITS;
   localparam int P2_W    = R_W + STEP_W + 1;
   localparam int A_W     = P2_W - FRACTION_BITS;
   localparam int ACC_W   = (A_W > ANGLE_BITS) ? A_W : ANGLE_BITS;
   localparam int STEP_CW = $clog2(SUM_W);

   // lane registers
   logic signed [SAMPLE_BITS-1:0] sample_ff    [NUM_AXES];
   logic signed [SUM_W-1:0]       sum_ff       [NUM_AXES];
   logic signed [SAMPLE_BITS-1:0] bias_ff      [NUM_AXES];
   logic signed [P1_W-1:0]        prod1_ff     [NUM_AXES];
   logic signed [P2_W-1:0]        prod2_ff     [NUM_AXES];
   logic [ANGLE_BITS-1:0]         angle_ff     [NUM_AXES];
   logic [ANGLE_BITS-1:0]         out_angle_ff [NUM_AXES];
   logic                          out_cal_ff;
   logic [CNT_W-1:0]              seen_ff;

   // divider registers
   logic                          div_busy_ff;
   logic [AXIS_W-1:0]             div_axis_ff;
   logic [STEP_CW-1:0]            div_step_ff;
   logic [SUM_W-1:0]              div_num_ff;
   logic [CNT_W-1:0]              div_rem_ff;
   logic                          div_neg_ff;

   // lane combinational values
   logic signed [GAIN_W:0]        gain_s;
   logic signed [STEP_W:0]        step_s;
   logic signed [D_W-1:0]         diff      [NUM_AXES];
   logic signed [P1_W-1:0]        prod1_in  [NUM_AXES];
   logic signed [R_W-1:0]         rate_scl  [NUM_AXES];
   logic signed [P2_W-1:0]        prod2_in  [NUM_AXES];
   logic signed [A_W-1:0]         delta     [NUM_AXES];
   logic [ACC_W-1:0]              angle_wide[NUM_AXES];
   logic [ANGLE_BITS-1:0]         angle_in  [NUM_AXES];
   logic signed [SUM_W-1:0]       sum_in    [NUM_AXES];

   // divider combinational values
   logic [CNT_W:0]                div_trial;
   logic [CNT_W:0]                div_diff;
   logic                          div_ge;
   logic [CNT_W-1:0]              rem_in;
   logic [SUM_W-1:0]              quot_in;
   logic [SUM_W-1:0]              quot_signed;
   logic                          last_step;
   logic [AXIS_W-1:0]             load_idx;
   logic signed [SUM_W-1:0]       load_sum;
   logic [SUM_W-1:0]              load_mag;

   assign gain_s = signed'({1'b0, cfg.rate_gain});
   assign step_s = signed'({1'b0, cfg.time_step});

   // count completes when this sample is added
   assign status.cal_reached = ((CNT_W+1)'(seen_ff) + (CNT_W+1)'(1)) >= {1'b0, cfg.cal_count};
   assign status.div_busy    = div_busy_ff;

   // per-axis arithmetic: bias removal, two scaled products, wrapping accumulate
   always_comb begin
      for (int i = 0; i < NUM_AXES; i++) begin
         diff[i]       = D_W'(sample_ff[i]) - D_W'(bias_ff[i]);
         prod1_in[i]   = P1_W'(diff[i]) * P1_W'(gain_s);
         rate_scl[i]   = R_W'(prod1_ff[i] >>> FRACTION_BITS);
         prod2_in[i]   = P2_W'(rate_scl[i]) * P2_W'(step_s);
         delta[i]      = A_W'(prod2_ff[i] >>> FRACTION_BITS);
         angle_wide[i] = ACC_W'(angle_ff[i]) + ACC_W'(delta[i]);
         angle_in[i]   = angle_wide[i][ANGLE_BITS-1:0];
         sum_in[i]     = sum_ff[i] + SUM_W'(sample_ff[i]);
      end
   end

   // restoring divide step, one quotient bit per cycle
   always_comb begin
      div_trial   = {div_rem_ff, div_num_ff[SUM_W-1]};
      div_diff    = div_trial - {1'b0, seen_ff};
      div_ge      = (div_trial >= {1'b0, seen_ff});
      rem_in      = div_ge ? div_diff[CNT_W-1:0] : div_trial[CNT_W-1:0];
      quot_in     = {div_num_ff[SUM_W-2:0], div_ge};
      quot_signed = div_neg_ff ? (-quot_in) : quot_in;
      last_step   = (div_step_ff == STEP_CW'(SUM_W - 1));
      if (cmd.div_start || div_axis_ff == AXIS_LAST) begin
         load_idx = AXIS_FIRST;
      end else begin
         load_idx = div_axis_ff + 1'b1;
      end
      load_sum = sum_ff[load_idx];
      load_mag = load_sum[SUM_W-1] ? SUM_W'(-load_sum) : SUM_W'(load_sum);
   end

   // sample capture and multiply stages
   always_ff @(posedge clock) begin
      for (int i = 0; i < NUM_AXES; i++) begin
         if (cmd.mul1) begin
            prod1_ff[i] <= prod1_in[i];
         end
         if (cmd.mul2) begin
            prod2_ff[i] <= prod2_in[i];
         end
      end
      if (cmd.load_sample) begin
         sample_ff[0] <= in_rate_x;
         sample_ff[1] <= in_rate_y;
         sample_ff[2] <= in_rate_z;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.acc_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            out_angle_ff[i] <= angle_in[i];
         end
         out_cal_ff <= 1'b0;
      end else if (cmd.cal_load) begin
         for (int i = 0; i < NUM_AXES; i++) begin
            out_angle_ff[i] <= '0;
         end
         out_cal_ff <= 1'b1;
      end
   end

   // calibration sums, bias divider, angle accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff     <= '0;
         div_busy_ff <= 1'b0;
         div_axis_ff <= AXIS_FIRST;
         div_step_ff <= '0;
         div_rem_ff  <= '0;
         div_num_ff  <= '0;
         div_neg_ff  <= 1'b0;
         for (int i = 0; i < NUM_AXES; i++) begin
            sum_ff[i]   <= '0;
            bias_ff[i]  <= '0;
            angle_ff[i] <= '0;
         end
      end else begin
         if (cmd.cal_add) begin
            seen_ff <= seen_ff + 1'b1;
            for (int i = 0; i < NUM_AXES; i++) begin
               sum_ff[i] <= sum_in[i];
            end
         end

         if (cmd.acc_load) begin
            for (int i = 0; i < NUM_AXES; i++) begin
               angle_ff[i] <= angle_in[i];
            end
         end

         if (cmd.div_start) begin
            div_busy_ff <= 1'b1;
            div_axis_ff <= AXIS_FIRST;
            div_step_ff <= '0;
            div_rem_ff  <= '0;
            div_num_ff  <= load_mag;
            div_neg_ff  <= load_sum[SUM_W-1];
         end else if (div_busy_ff) begin
            if (last_step) begin
               bias_ff[div_axis_ff] <= quot_signed[SAMPLE_BITS-1:0];
               div_step_ff          <= '0;
               div_rem_ff           <= '0;
               if (div_axis_ff == AXIS_LAST) begin
                  div_busy_ff <= 1'b0;
               end else begin
                  div_axis_ff <= load_idx;
                  div_num_ff  <= load_mag;
                  div_neg_ff  <= load_sum[SUM_W-1];
               end
            end else begin
               div_step_ff <= div_step_ff + 1'b1;
               div_rem_ff  <= rem_in;
               div_num_ff  <= quot_in;
            end
         end
      end
   end

   assign out_angle_x     = out_angle_ff[0];
   assign out_angle_y     = out_angle_ff[1];
   assign out_angle_z     = out_angle_ff[2];
   assign out_calibrating = out_cal_ff;

endmodule

`default_nettype wire
